@@ rtl/stcg_pkg.sv @@
`default_nettype none

package stcg_pkg;

	localparam int unsigned MAX_ROWS = 128;

	localparam int unsigned DIV_BITS = 16;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_BITS);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_BITS - 1);

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_X = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_COLUMNS = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_ROWS = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_FULL_SCALE = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_SWEEP_MODE = 3'd6;

	localparam logic [1:0] MODE_FORWARD = 2'd0;
	localparam logic [1:0] MODE_BACKWARD = 2'd1;
	localparam logic [1:0] MODE_GIVEN = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP_DIV,
		ST_ROW_DIV,
		ST_FINISH,
		ST_EMIT_TRACE,
		ST_EMIT_CURSOR
	} stcg_state_t;

	typedef struct packed {
		logic accept;
		logic div_step;
		logic step_done;
		logic row_done;
		logic commit;
		logic load_cursor;
	} stcg_cmd_t;

	typedef struct packed {
		logic step_valid;
		logic div_last;
		logic cursor;
	} stcg_sts_t;

endpackage

`default_nettype wire

@@ rtl/stcg_sample_if.sv @@
`default_nettype none

interface stcg_sample_if;
	logic        valid;
	logic        ready;
	logic [15:0] sample;
	logic [7:0]  given_column;

	modport source (output valid, output sample, output given_column, input ready);
	modport sink (input valid, input sample, input given_column, output ready);
endinterface

`default_nettype wire

@@ rtl/stcg_result_if.sv @@
`default_nettype none

interface stcg_result_if;
	logic       valid;
	logic       ready;
	logic       is_cursor;
	logic [8:0] screen_x;
	logic [8:0] screen_y;
	logic [7:0] pixel_count;
	logic [6:0] lit_low;
	logic [6:0] lit_high;
	logic       last;

	modport source (
		output valid, output is_cursor, output screen_x, output screen_y,
		output pixel_count, output lit_low, output lit_high, output last,
		input ready
	);
	modport sink (
		input valid, input is_cursor, input screen_x, input screen_y,
		input pixel_count, input lit_low, input lit_high, input last,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/stcg_cfg_if.sv @@
`default_nettype none

interface stcg_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/stcg_ctrl.sv @@
`default_nettype none

module stcg_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire stcg_pkg::stcg_sts_t sts,
	output stcg_pkg::stcg_cmd_t    cmd
);

	stcg_pkg::stcg_state_t state_q;
	stcg_pkg::stcg_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stcg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			stcg_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = sts.step_valid ? stcg_pkg::ST_ROW_DIV : stcg_pkg::ST_STEP_DIV;
				end
			end
			stcg_pkg::ST_STEP_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					cmd.step_done = 1'b1;
					state_d = stcg_pkg::ST_ROW_DIV;
				end
			end
			stcg_pkg::ST_ROW_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					cmd.row_done = 1'b1;
					state_d = stcg_pkg::ST_FINISH;
				end
			end
			stcg_pkg::ST_FINISH: begin
				cmd.commit = 1'b1;
				state_d = stcg_pkg::ST_EMIT_TRACE;
			end
			stcg_pkg::ST_EMIT_TRACE: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (sts.cursor) begin
						cmd.load_cursor = 1'b1;
						state_d = stcg_pkg::ST_EMIT_CURSOR;
					end else begin
						state_d = stcg_pkg::ST_IDLE;
					end
				end
			end
			stcg_pkg::ST_EMIT_CURSOR: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = stcg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = stcg_pkg::ST_IDLE;
			end
		endcase
	end

`ifndef SYNTH
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input taken while a result is pending");

	a_cursor_follows_trace: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == stcg_pkg::ST_EMIT_CURSOR) |->
		($past(state_q) == stcg_pkg::ST_EMIT_TRACE || $past(state_q) == stcg_pkg::ST_EMIT_CURSOR))
		else $error("cursor result without a preceding trace result");
`endif

endmodule

`default_nettype wire

@@ rtl/stcg_dp.sv @@
`default_nettype none

module stcg_dp (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire stcg_pkg::stcg_cmd_t                   cmd,
	output stcg_pkg::stcg_sts_t                        sts,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [stcg_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  wire logic [stcg_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire logic [15:0]                           sample,
	input  wire logic [7:0]                            given_column,
	output logic                                       is_cursor,
	output logic [8:0]                                 screen_x,
	output logic [8:0]                                 screen_y,
	output logic [7:0]                                 pixel_count,
	output logic [6:0]                                 lit_low,
	output logic [6:0]                                 lit_high,
	output logic                                       last
);

	logic [7:0]  origin_x_q;
	logic [7:0]  origin_y_q;
	logic [7:0]  frame_width_q;
	logic [7:0]  window_columns_q;
	logic [7:0]  window_rows_q;
	logic [15:0] full_scale_q;
	logic [1:0]  sweep_mode_q;

	logic [8:0]  sweep_col_q;
	logic [6:0]  prev_row_q;
	logic        step_valid_q;
	logic        cursor_q;

	logic [15:0] step_q;
	logic [15:0] sample_q;
	logic [7:0]  given_q;
	logic [6:0]  row_q;
	logic [8:0]  next_col_q;

	logic [15:0] rem_q;
	logic [15:0] quo_q;
	logic [15:0] div_q;
	logic [stcg_pkg::DIV_CNT_W-1:0] cnt_q;

	logic cfg_we;
	logic step_clear;

	logic [7:0]  rows_c;
	logic [6:0]  rmax;
	logic [7:0]  limit;

	logic [16:0] shifted;
	logic        ge;
	logic [16:0] diff;
	logic [15:0] rem_next;
	logic [15:0] quo_next;
	logic [15:0] step_nz;
	logic [6:0]  row_clamped;

	logic        is_fwd;
	logic        is_bwd;
	logic [8:0]  col_c;
	logic        start_c;
	logic [6:0]  prev_eff;
	logic [6:0]  lo_c;
	logic [6:0]  hi_c;
	logic [8:0]  fwd_next;
	logic [8:0]  bwd_next;
	logic signed [10:0] bound;
	logic signed [10:0] given_s;
	logic        cursor_c;
	logic [8:0]  next_c;
	logic [8:0]  sweep_next_c;
	logic [8:0]  base_x;

	assign cfg_ready = 1'b1;
	assign cfg_we = cfg_valid && cfg_ready;
	assign step_clear = cfg_we &&
		(cfg_index == stcg_pkg::CFG_FULL_SCALE || cfg_index == stcg_pkg::CFG_WINDOW_ROWS);

	always_comb begin
		if (window_rows_q < 8'd2) begin
			rows_c = 8'd2;
		end else if (window_rows_q > 8'(stcg_pkg::MAX_ROWS)) begin
			rows_c = 8'(stcg_pkg::MAX_ROWS);
		end else begin
			rows_c = window_rows_q;
		end
	end
	assign rmax = 7'(rows_c - 8'd1);
	assign limit = (window_columns_q > frame_width_q) ? (window_columns_q - frame_width_q) : 8'd0;

	// One restoring division step: one quotient bit per cycle, MSB first.
	assign shifted = {rem_q, quo_q[15]};
	assign diff = shifted - {1'b0, div_q};
	assign ge = (shifted >= {1'b0, div_q});
	assign rem_next = ge ? diff[15:0] : shifted[15:0];
	assign quo_next = {quo_q[14:0], ge};
	assign step_nz = (quo_next == 16'd0) ? 16'd1 : quo_next;
	assign row_clamped = (quo_next > {9'd0, rmax}) ? rmax : quo_next[6:0];

	assign is_fwd = (sweep_mode_q == stcg_pkg::MODE_FORWARD);
	assign is_bwd = (sweep_mode_q == stcg_pkg::MODE_BACKWARD);

	assign fwd_next = sweep_col_q + 9'd1;
	assign bwd_next = sweep_col_q - 9'd1;
	assign bound = $signed({3'b000, window_columns_q}) - $signed({2'b00, frame_width_q, 1'b0});
	assign given_s = $signed({3'b000, given_q});

	always_comb begin
		if (is_fwd) begin
			col_c = sweep_col_q;
			start_c = (sweep_col_q == 9'd0);
			cursor_c = (fwd_next < {1'b0, limit});
			next_c = fwd_next;
			sweep_next_c = cursor_c ? fwd_next : 9'd0;
		end else if (is_bwd) begin
			col_c = sweep_col_q;
			start_c = (sweep_col_q == {1'b0, limit});
			cursor_c = (sweep_col_q != 9'd0);
			next_c = bwd_next;
			sweep_next_c = cursor_c ? bwd_next : {1'b0, limit};
		end else begin
			col_c = {1'b0, given_q};
			start_c = (given_q == 8'd0);
			cursor_c = (given_s < bound);
			next_c = {1'b0, given_q} + 9'd1;
			sweep_next_c = sweep_col_q;
		end
	end

	assign prev_eff = start_c ? row_q : prev_row_q;
	assign lo_c = (prev_eff < row_q) ? prev_eff : row_q;
	assign hi_c = (prev_eff < row_q) ? row_q : prev_eff;
	assign base_x = {1'b0, origin_x_q} + {1'b0, frame_width_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= 8'd0;
			origin_y_q <= 8'd0;
			frame_width_q <= 8'd1;
			window_columns_q <= 8'd160;
			window_rows_q <= 8'd128;
			full_scale_q <= 16'd4095;
			sweep_mode_q <= stcg_pkg::MODE_FORWARD;
		end else if (cfg_we) begin
			case (cfg_index)
				stcg_pkg::CFG_ORIGIN_X: origin_x_q <= cfg_data[7:0];
				stcg_pkg::CFG_ORIGIN_Y: origin_y_q <= cfg_data[7:0];
				stcg_pkg::CFG_FRAME_WIDTH: frame_width_q <= cfg_data[7:0];
				stcg_pkg::CFG_WINDOW_COLUMNS: window_columns_q <= cfg_data[7:0];
				stcg_pkg::CFG_WINDOW_ROWS: window_rows_q <= cfg_data[7:0];
				stcg_pkg::CFG_FULL_SCALE: full_scale_q <= cfg_data;
				stcg_pkg::CFG_SWEEP_MODE: sweep_mode_q <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_col_q <= 9'd0;
			prev_row_q <= 7'd0;
			step_valid_q <= 1'b0;
			cursor_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (step_clear) begin
				step_valid_q <= 1'b0;
			end else if (cmd.step_done) begin
				step_valid_q <= 1'b1;
			end
			if (cmd.accept || cmd.step_done) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.commit) begin
				sweep_col_q <= sweep_next_c;
				prev_row_q <= row_q;
				cursor_q <= cursor_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= sample;
			given_q <= given_column;
			rem_q <= 16'd0;
			if (step_valid_q) begin
				quo_q <= sample;
				div_q <= step_q;
			end else begin
				quo_q <= full_scale_q;
				div_q <= {9'd0, rmax};
			end
		end else if (cmd.step_done) begin
			step_q <= step_nz;
			rem_q <= 16'd0;
			quo_q <= sample_q;
			div_q <= step_nz;
		end else if (cmd.div_step) begin
			rem_q <= rem_next;
			quo_q <= quo_next;
		end
		if (cmd.row_done) begin
			row_q <= row_clamped;
		end
		if (cmd.commit) begin
			next_col_q <= next_c;
			is_cursor <= 1'b0;
			screen_x <= col_c + base_x;
			screen_y <= {1'b0, origin_y_q} + {1'b0, frame_width_q};
			pixel_count <= (window_rows_q > frame_width_q) ?
				(window_rows_q - frame_width_q) : 8'd0;
			lit_low <= lo_c;
			lit_high <= hi_c;
			last <= !cursor_c;
		end else if (cmd.load_cursor) begin
			is_cursor <= 1'b1;
			screen_x <= next_col_q + base_x;
			lit_low <= 7'd0;
			lit_high <= 7'd0;
			last <= 1'b1;
		end
	end

	assign sts.step_valid = step_valid_q;
	assign sts.div_last = (cnt_q == stcg_pkg::DIV_LAST);
	assign sts.cursor = cursor_q;

`ifndef SYNTH
	a_step_invalidated: assert property (@(posedge clk) disable iff (!arst_n)
		step_clear |=> !step_valid_q)
		else $error("cached step survived a scale or row count change");
`endif

endmodule

`default_nettype wire

@@ rtl/scrolling_trace_column_generator_core.sv @@
`default_nettype none

// Scrolling trace column generator. Each sample transfer yields a trace column result and,
// when the next column is still inside the window, a cursor column result; last marks the
// final one. A sample is accepted, its row is found by bit-serial division by the scale
// step, the result is formed, and then each result is transferred when the sink is ready.
// After reset, and after full_scale or window_rows is written, the next sample first
// passes through the same divider to work out the new scale step, which is then kept for
// later samples. One sample is in work at a time. Configuration is written by the user
// only while the block is idle (not enforced); the configuration port is always ready.
module scrolling_trace_column_generator_core (
	input  wire logic     clk,
	input  wire logic     arst_n,
	stcg_sample_if.sink   samples,
	stcg_result_if.source results,
	stcg_cfg_if.sink      cfg
);

	stcg_pkg::stcg_cmd_t cmd;
	stcg_pkg::stcg_sts_t sts;
	logic in_ready;
	logic out_valid;
	logic cfg_ready;

	stcg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (results.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	stcg_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_valid    (cfg.valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.sample       (samples.sample),
		.given_column (samples.given_column),
		.is_cursor    (results.is_cursor),
		.screen_x     (results.screen_x),
		.screen_y     (results.screen_y),
		.pixel_count  (results.pixel_count),
		.lit_low      (results.lit_low),
		.lit_high     (results.lit_high),
		.last         (results.last)
	);

	assign samples.ready = in_ready;
	assign results.valid = out_valid;
	assign cfg.ready = cfg_ready;

endmodule

`default_nettype wire
